FILE: rtl/soa_pkg.sv
// Package for the Sieve of Atkin prime table: payload types, controller
// command/status structs, constants and mod-60 residue tests. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package soa_pkg;
   localparam int unsigned MaxNumberDefault = 65536;

   typedef enum logic {
      FUNC_BUILD = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [15:0] number;
   } req_type;

   typedef struct packed {
      logic is_prime;
      logic out_of_range;
      logic table_ready;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic start_build;   // latch limit, reset build counters
      logic clear_step;    // clear one entry, advance
      logic form_step;     // one (x,y) form pass step
      logic square_step;   // one elimination step
      logic fix_step;      // one small-prime fixup step
      logic query_read;    // issue table read for query
      logic finish_build;  // record built limit
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic form_done;
      logic square_done;
      logic fix_done;
   } dp_status_type;

   function automatic logic res_a(input logic [5:0] r);
      return r == 6'd1 || r == 6'd13 || r == 6'd17 || r == 6'd29 ||
             r == 6'd37 || r == 6'd41 || r == 6'd49 || r == 6'd53;
   endfunction
   function automatic logic res_b(input logic [5:0] r);
      return r == 6'd7 || r == 6'd19 || r == 6'd31 || r == 6'd43;
   endfunction
   function automatic logic res_c(input logic [5:0] r);
      return r == 6'd11 || r == 6'd23 || r == 6'd47 || r == 6'd59;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/sieve_of_atkin_prime_table.sv
// Sieve of Atkin prime table. A query does one registered RAM read at the
// held address, and the next item can transfer in the cycle its result
// transfers. A build clears the bitmap from 0 to limit (finding isqrt(limit)
// on the way), steps through every (x,y) pair with x,y in 1..isqrt(limit)
// for the three quadratic forms (read-modify-write on the single RAM port),
// then reads each candidate from 5 to isqrt(limit) and, if it is marked,
// clears its square multiples, and last marks those of 2, 3 and 5 that are
// not above the limit; it is busy until its result is taken.
// A limit at or above MaxNumber builds up to MaxNumber-1.
// A query before any build returns table_ready 0.
// Depends on soa_pkg, soa_ctrl, soa_dp.
`timescale 1ns / 1ps
`default_nettype none
module sieve_of_atkin_prime_table #(
   parameter int unsigned MaxNumber = soa_pkg::MaxNumberDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire soa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output soa_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data
);
   import soa_pkg::*;

   logic [15:0]   limit_ff;
   logic          is_query;
   dp_cmd_type    cmd;
   dp_status_type stat;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 16'd100;
      else if (csr_wr_en) limit_ff <= csr_wr_data;
   end

   soa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .is_query, .cmd, .stat
   );

   soa_dp #(.MaxNumber(MaxNumber)) u_dp (
      .clock, .reset, .limit(limit_ff), .number(req_data.number), .is_query,
      .cmd, .stat, .rsp(rsp_data)
   );
endmodule
`default_nettype wire

FILE: rtl/soa_ram.sv
// Generic single-port RAM, registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module soa_ram #(
   parameter int unsigned Width = 1,
   parameter int unsigned Depth = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/soa_ctrl.sv
// Build/query sequencer for the prime table. Depends on soa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module soa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire soa_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       is_query,
   output soa_pkg::dp_cmd_type        cmd,
   input  wire soa_pkg::dp_status_type stat
);
   import soa_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_FORM   = 7'b0000100,
      ST_SQUARE = 7'b0001000,
      ST_FIX    = 7'b0010000,
      ST_QUERY  = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      query_ff, query_in;
   logic      accept;

   assign accept    = req_valid && !req_stall;
   // ready again as soon as a pending result leaves
   assign req_stall = !(state_ff == ST_IDLE || (state_ff == ST_RESP && !rsp_stall));
   assign rsp_valid = state_ff == ST_RESP;
   assign is_query  = query_ff;

   always_comb begin
      state_in = state_ff;
      query_in = query_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE, ST_RESP: begin
            if (state_ff == ST_RESP && !rsp_stall) state_in = ST_IDLE;
            if (accept) begin
               query_in = req_data.func == FUNC_QUERY;
               if (req_data.func == FUNC_QUERY) begin
                  cmd.query_read = 1'b1;
                  state_in = ST_QUERY;
               end else begin
                  cmd.start_build = 1'b1;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.form_step = 1'b1;
            if (stat.form_done) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square_step = 1'b1;
            if (stat.square_done) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix_step = 1'b1;
            if (stat.fix_done) begin
               cmd.finish_build = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_QUERY: state_in = ST_RESP;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         query_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         query_ff <= query_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_RESP) |-> req_stall)
      else $error("accept while busy");
endmodule
`default_nettype wire

FILE: rtl/soa_dp.sv
// Datapath for the prime table: bitmap RAM, form/elimination counters,
// read-modify-write. Depends on soa_pkg and soa_ram.
`timescale 1ns / 1ps
`default_nettype none
module soa_dp #(
   parameter int unsigned MaxNumber = soa_pkg::MaxNumberDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [15:0]            limit,
   input  wire logic [15:0]            number,
   input  wire logic                   is_query,
   input  wire soa_pkg::dp_cmd_type    cmd,
   output soa_pkg::dp_status_type      stat,
   output soa_pkg::rsp_type            rsp
);
   import soa_pkg::*;

   localparam int unsigned AW  = $clog2(MaxNumber);
   localparam int unsigned VW  = 26;               // holds 4x^2+y^2 for 16-bit limits
   localparam logic [16:0] Sat = 17'(MaxNumber - 1);

   // reduce a value below 300 to its residue mod 60
   function automatic logic [5:0] fold60(input logic [8:0] v);
      logic [8:0] r;
      if (v >= 9'd240)      r = v - 9'd240;
      else if (v >= 9'd180) r = v - 9'd180;
      else if (v >= 9'd120) r = v - 9'd120;
      else if (v >= 9'd60)  r = v - 9'd60;
      else                  r = v;
      return r[5:0];
   endfunction

   // build registers
   logic [15:0] lim_ff, lim_in;
   logic [15:0] blim_ff, blim_in;
   logic        built_ff, built_in;
   logic [8:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in, root_ff, root_in;
   logic [16:0] cnt_ff, cnt_in;      // clear address / multiple / fixup index
   logic [16:0] sq_ff, sq_in;
   logic [2:0]  ph_ff, ph_in;        // sub-step within form/elimination
   logic [16:0] z_ff, z_in;          // target entry
   logic        flip_ff, flip_in;
   logic [VW-1:0] xx_ff, xx_in, yy_ff, yy_in;
   // x^2, y^2 mod 60 and their next increments (2x+1, 2y+1) mod 60
   logic [5:0]  xr_ff, xr_in, dx_ff, dx_in, yr_ff, yr_in, dy_ff, dy_in;
   logic        qry_ff;
   logic [15:0] qnum_ff;

   // RAM port
   logic          wr_en;
   logic [AW-1:0] addr;
   logic          wr_data, rd_data;

   soa_ram #(.Width(1), .Depth(MaxNumber)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   logic [VW-1:0] za, zb, zc, zsel;
   logic [5:0]    rsel;
   logic          hit;
   logic [16:0]   lim_ext;

   assign lim_ext = {1'b0, lim_ff};
   assign za = (xx_ff << 2) + yy_ff;
   assign zb = (xx_ff << 1) + xx_ff + yy_ff;
   assign zc = (xx_ff << 1) + xx_ff - yy_ff;

   // form steps: ph 0 pick a, 1 wait read, 2 write; ph 3..5 b; ph 6.. c
   always_comb begin
      case (ph_ff)
         3'd0:    zsel = za;
         3'd3:    zsel = zb;
         default: zsel = zc;
      endcase
      case (ph_ff)
         3'd0:    rsel = fold60(9'({xr_ff, 2'b00}) + 9'(yr_ff));
         3'd3:    rsel = fold60(9'({xr_ff, 1'b0}) + 9'(xr_ff) + 9'(yr_ff));
         default: rsel = fold60(9'({xr_ff, 1'b0}) + 9'(xr_ff) + 9'd60 - 9'(yr_ff));
      endcase
      case (ph_ff)
         3'd0:    hit = res_a(rsel);
         3'd3:    hit = res_b(rsel);
         default: hit = res_c(rsel) && x_ff > {1'b0, y_ff};
      endcase
      hit = hit && zsel <= VW'(lim_ff);
   end

   always_comb begin
      lim_in   = lim_ff;   blim_in = blim_ff; built_in = built_ff;
      x_in     = x_ff;     y_in    = y_ff;    root_in  = root_ff;
      cnt_in   = cnt_ff;   sq_in   = sq_ff;   ph_in    = ph_ff;
      z_in     = z_ff;     flip_in = flip_ff;
      xx_in    = xx_ff;    yy_in   = yy_ff;
      xr_in    = xr_ff;    dx_in   = dx_ff;   yr_in    = yr_ff;   dy_in = dy_ff;
      wr_en    = 1'b0;     wr_data = 1'b0;
      // hold the queried entry on the port so the result stays put while stalled
      addr     = is_query ? AW'(qnum_ff) : AW'(cnt_ff);
      stat     = '0;

      if (cmd.start_build) begin
         lim_in  = ({1'b0, limit} > Sat) ? Sat[15:0] : limit;
         cnt_in  = '0;
         root_in = '0;
         x_in    = 9'd1; y_in = 8'd1;
         xx_in   = VW'(1); yy_in = VW'(1);
         xr_in   = 6'd1; dx_in = 6'd3; yr_in = 6'd1; dy_in = 6'd3;
         ph_in   = '0;
      end
      if (cmd.query_read) addr = AW'(number);

      if (cmd.clear_step) begin
         // clear entries and find isqrt(limit) in the same sweep
         wr_en = 1'b1;
         if (17'((root_ff + 17'd1) * (root_ff + 17'd1)) <= lim_ext && root_ff != 8'hff)
            root_in = root_ff + 8'd1;
         cnt_in = cnt_ff + 17'd1;
         if (cnt_ff >= lim_ext) begin
            stat.clear_done = 1'b1;
            cnt_in = '0;
         end
      end

      if (cmd.form_step) begin
         if (root_ff == 0) begin
            stat.form_done = 1'b1;
         end else begin
            case (ph_ff)
               3'd0, 3'd3, 3'd6: begin
                  z_in    = 17'(zsel);
                  flip_in = hit;
                  addr    = AW'(zsel);
                  ph_in   = ph_ff + 3'd1;
               end
               3'd1, 3'd4: begin
                  addr  = AW'(z_ff);
                  ph_in = ph_ff + 3'd1;
               end
               3'd2, 3'd5: begin
                  addr    = AW'(z_ff);
                  wr_en   = flip_ff;
                  wr_data = !rd_data;
                  ph_in   = ph_ff + 3'd1;
               end
               default: begin
                  // ph 7: write form c, advance x,y
                  addr    = AW'(z_ff);
                  wr_en   = flip_ff;
                  wr_data = !rd_data;
                  ph_in   = '0;
                  if (y_ff == root_ff) begin
                     y_in  = 8'd1; yy_in = VW'(1);
                     yr_in = 6'd1; dy_in = 6'd3;
                     x_in  = x_ff + 9'd1;
                     xx_in = xx_ff + VW'({x_ff, 1'b0}) + VW'(1);
                     xr_in = fold60(9'(xr_ff) + 9'(dx_ff));
                     dx_in = fold60(9'(dx_ff) + 9'd2);
                     if (x_ff == {1'b0, root_ff}) begin
                        stat.form_done = 1'b1;
                        x_in = 9'd5; cnt_in = '0;
                     end
                  end else begin
                     y_in  = y_ff + 8'd1;
                     yy_in = yy_ff + VW'({y_ff, 1'b0}) + VW'(1);
                     yr_in = fold60(9'(yr_ff) + 9'(dy_ff));
                     dy_in = fold60(9'(dy_ff) + 9'd2);
                  end
               end
            endcase
            // c phase reads in ph 6 and writes in ph 7, with no wait phase
            if (ph_ff == 3'd6) begin
               ph_in = 3'd7;
            end
         end
         if (stat.form_done) begin
            x_in = 9'd5; ph_in = '0;
         end
      end

      if (cmd.square_step) begin
         // ph0 read x, ph1 wait, ph2 decide, ph3 clear multiples
         case (ph_ff)
            3'd0: begin
               if (x_ff > {1'b0, root_ff}) begin
                  stat.square_done = 1'b1;
                  cnt_in = '0;
               end else begin
                  addr  = AW'(x_ff);
                  ph_in = 3'd1;
               end
            end
            3'd1: begin
               addr  = AW'(x_ff);
               ph_in = 3'd2;
               sq_in = 17'(x_ff * x_ff);
            end
            3'd2: begin
               cnt_in = sq_ff;
               if (rd_data) ph_in = 3'd3;
               else begin
                  ph_in = 3'd0; x_in = x_ff + 9'd1;
               end
            end
            default: begin
               addr = AW'(cnt_ff);
               if (cnt_ff <= lim_ext) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + sq_ff;
                  if (cnt_in < cnt_ff) cnt_in = 17'h1ffff;
               end else begin
                  ph_in = 3'd0; x_in = x_ff + 9'd1;
               end
            end
         endcase
      end

      if (cmd.fix_step) begin
         case (cnt_ff[1:0])
            2'd0:    addr = AW'(2);
            2'd1:    addr = AW'(3);
            default: addr = AW'(5);
         endcase
         wr_data = 1'b1;
         case (cnt_ff[1:0])
            2'd0:    wr_en = lim_ff >= 16'd2;
            2'd1:    wr_en = lim_ff >= 16'd3;
            default: wr_en = lim_ff >= 16'd5;
         endcase
         cnt_in = cnt_ff + 17'd1;
         if (cnt_ff[1:0] == 2'd2) stat.fix_done = 1'b1;
      end

      if (cmd.finish_build) begin
         blim_in  = lim_ff;
         built_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         built_ff <= 1'b0;
         blim_ff  <= '0;
         ph_ff    <= '0;
      end else begin
         built_ff <= built_in;
         blim_ff  <= blim_in;
         ph_ff    <= ph_in;
      end
      lim_ff <= lim_in; x_ff <= x_in; y_ff <= y_in; root_ff <= root_in;
      cnt_ff <= cnt_in; sq_ff <= sq_in; z_ff <= z_in; flip_ff <= flip_in;
      xx_ff <= xx_in; yy_ff <= yy_in;
      xr_ff <= xr_in; dx_ff <= dx_in; yr_ff <= yr_in; dy_ff <= dy_in;
      if (cmd.query_read) qnum_ff <= number;
      qry_ff <= is_query;
   end

   always_comb begin
      rsp.table_ready  = built_ff;
      rsp.is_prime     = 1'b0;
      rsp.out_of_range = 1'b0;
      if (qry_ff && built_ff) begin
         if (qnum_ff > blim_ff) rsp.out_of_range = 1'b1;
         else rsp.is_prime = rd_data;
      end
   end
endmodule
`default_nettype wire
